FILE: design/gkps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gkps_pkg;

  localparam int MAX_POINTS = 256;
  localparam int IDX_BITS   = $clog2(MAX_POINTS);
  localparam int CNT_BITS   = IDX_BITS + 1;
  localparam int COORD_BITS = 12;
  localparam int RESP_BITS  = 16;
  localparam int RUN_CAP    = 64;
  localparam int EMIT_BITS  = 7;
  localparam int CFG_BITS   = 8;
  localparam int ENTRY_BITS = 2 * COORD_BITS + RESP_BITS;

  // Register indexes on the configuration port
  localparam logic REG_RADIUS     = 1'b0;
  localparam logic REG_FEAT_LIMIT = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
    logic [RESP_BITS-1:0]  point_response;
    logic                  is_last;
  } point_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] kept_x;
    logic [COORD_BITS-1:0] kept_y;
    logic [RESP_BITS-1:0]  kept_response;
    logic                  end_of_run;
    logic                  overflow;
  } point_out_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [RESP_BITS-1:0]  resp;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN_START,
    ST_SCAN,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic setup;
    logic scan_begin;
    logic decide;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic found;
    logic last_slot;
  } status_t;

endpackage
`default_nettype wire

FILE: design/gkps_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module gkps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/gkps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module gkps_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               is_last,
  input  wire gkps_pkg::status_t  status,
  output gkps_pkg::cmd_t          cmd,
  output logic                    busy
);

  gkps_pkg::state_t state, state_next;

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gkps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence load, scan rounds and final emission
  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      gkps_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start && is_last) begin
          state_next = gkps_pkg::ST_SETUP;
        end
      end
      gkps_pkg::ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = gkps_pkg::ST_SCAN_START;
      end
      gkps_pkg::ST_SCAN_START: begin
        cmd.scan_begin = 1'b1;
        state_next     = gkps_pkg::ST_SCAN;
      end
      gkps_pkg::ST_SCAN: begin
        if (status.scan_done) begin
          state_next = gkps_pkg::ST_DECIDE;
        end
      end
      gkps_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        if (!status.found || status.last_slot) begin
          state_next = gkps_pkg::ST_FINISH;
        end else begin
          state_next = gkps_pkg::ST_SCAN_START;
        end
      end
      gkps_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = gkps_pkg::ST_IDLE;
      end
      default: begin
        state_next = gkps_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/gkps_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module gkps_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            load,
  input  wire gkps_pkg::point_in_t             req,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [gkps_pkg::CFG_BITS-1:0]   cfg_data,
  input  wire gkps_pkg::cmd_t                  cmd,
  output gkps_pkg::status_t                    status,
  output logic                                 result_valid,
  output gkps_pkg::point_out_t                 result
);

  localparam int IB = gkps_pkg::IDX_BITS;
  localparam int CB = gkps_pkg::COORD_BITS;

  logic [7:0]                         radius;
  logic [gkps_pkg::EMIT_BITS-1:0]     feat_limit;
  logic [gkps_pkg::EMIT_BITS-1:0]     limit;
  logic [15:0]                        rad_sq;
  logic [gkps_pkg::CNT_BITS-1:0]      count;
  logic                               overflow_seen;
  logic [gkps_pkg::EMIT_BITS-1:0]     emit_cnt;

  logic                               issuing;
  logic [IB-1:0]                      rd_addr;
  gkps_pkg::entry_t                   rd_data;
  gkps_pkg::entry_t                   wr_entry;
  logic                               wr_en;

  logic                               flag_we;
  logic [IB-1:0]                      flag_waddr;
  logic [0:0]                         flag_wdata;
  logic [0:0]                         flag_rdata;

  logic                               v1, v2, v3;
  logic [IB-1:0]                      idx1, idx2, idx3;
  gkps_pkg::entry_t                   e2, e3;
  logic                               rm2, rm3;
  logic [CB-1:0]                      dx, dy;
  logic [2*CB-1:0]                    dx2, dy2;
  logic [2*CB:0]                      dist_sq;
  logic                               near3;
  logic                               drop_we;
  logic                               keep_we;
  logic                               take3;

  gkps_pkg::entry_t                   cur;
  logic                               have_cur;
  gkps_pkg::entry_t                   best;
  logic [IB-1:0]                      best_idx;
  logic                               best_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius     <= 8'd10;
      feat_limit <= gkps_pkg::EMIT_BITS'(gkps_pkg::RUN_CAP);
    end else if (cfg_we) begin
      case (cfg_index)
        gkps_pkg::REG_RADIUS:     radius     <= cfg_data;
        gkps_pkg::REG_FEAT_LIMIT: feat_limit <= cfg_data[gkps_pkg::EMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Store the arriving point while there is room
  assign wr_en    = load && (count < gkps_pkg::CNT_BITS'(gkps_pkg::MAX_POINTS));
  assign wr_entry = '{x: req.point_x, y: req.point_y, resp: req.point_response};

  gkps_ram #(
    .WIDTH(gkps_pkg::ENTRY_BITS),
    .DEPTH(gkps_pkg::MAX_POINTS)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(count[IB-1:0]),
    .wdata(wr_entry),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Suppressed flags: cleared as each point is stored, set on drop or keep
  assign near3      = have_cur && (dist_sq < {9'd0, rad_sq});
  assign drop_we    = v3 && !rm3 && near3;
  assign keep_we    = cmd.decide && best_valid;
  assign take3      = v3 && !rm3 && !near3 && (!best_valid || (e3.resp > best.resp));
  assign flag_we    = wr_en || drop_we || keep_we;
  assign flag_waddr = wr_en ? count[IB-1:0] : (drop_we ? idx3 : best_idx);
  assign flag_wdata = {!wr_en};

  gkps_ram #(
    .WIDTH(1),
    .DEPTH(gkps_pkg::MAX_POINTS)
  ) u_flags (
    .clk  (clk),
    .we   (flag_we),
    .waddr(flag_waddr),
    .wdata(flag_wdata),
    .raddr(rd_addr),
    .rdata(flag_rdata)
  );

  // Distance of the staged point to the current kept point
  always_comb begin
    dx = (rd_data.x > cur.x) ? rd_data.x - cur.x : cur.x - rd_data.x;
    dy = (rd_data.y > cur.y) ? rd_data.y - cur.y : cur.y - rd_data.y;
  end

  // Status toward the controller
  assign status.scan_done = !issuing && !v1 && !v2 && !v3;
  assign status.found     = best_valid;
  assign status.last_slot = (emit_cnt + 1'b1) == limit;

  // Control state: counts, scan pipeline, selection
  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      overflow_seen <= 1'b0;
      issuing       <= 1'b0;
      v1            <= 1'b0;
      v2            <= 1'b0;
      v3            <= 1'b0;
      have_cur      <= 1'b0;
      best_valid    <= 1'b0;
      emit_cnt      <= '0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= (cmd.decide && have_cur) || (cmd.finish && best_valid);
      if (wr_en) begin
        count <= count + 1'b1;
      end else if (load) begin
        overflow_seen <= 1'b1;
      end
      if (cmd.setup) begin
        have_cur <= 1'b0;
        emit_cnt <= '0;
      end
      // Issue reads over the stored points
      if (cmd.scan_begin) begin
        issuing <= 1'b1;
      end else if (issuing && ({1'b0, rd_addr} == count - 1'b1)) begin
        issuing <= 1'b0;
      end
      v1 <= issuing;
      v2 <= v1;
      v3 <= v2;
      // Track the strongest survivor
      if (cmd.scan_begin) begin
        best_valid <= 1'b0;
      end else if (take3) begin
        best_valid <= 1'b1;
      end
      // Advance to the next kept point
      if (keep_we) begin
        have_cur <= 1'b1;
        emit_cnt <= emit_cnt + 1'b1;
      end
      if (cmd.finish) begin
        count         <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      rad_sq <= {8'd0, radius} * {8'd0, radius};
      if (feat_limit == '0) begin
        limit <= gkps_pkg::EMIT_BITS'(1);
      end else if (feat_limit > gkps_pkg::EMIT_BITS'(gkps_pkg::RUN_CAP)) begin
        limit <= gkps_pkg::EMIT_BITS'(gkps_pkg::RUN_CAP);
      end else begin
        limit <= feat_limit;
      end
    end
    if (cmd.scan_begin) begin
      rd_addr <= '0;
    end else if (issuing) begin
      rd_addr <= rd_addr + 1'b1;
    end
    idx1    <= rd_addr;
    idx2    <= idx1;
    idx3    <= idx2;
    e2      <= rd_data;
    e3      <= e2;
    rm2     <= flag_rdata[0];
    rm3     <= rm2;
    dx2     <= {{CB{1'b0}}, dx} * {{CB{1'b0}}, dx};
    dy2     <= {{CB{1'b0}}, dy} * {{CB{1'b0}}, dy};
    dist_sq <= {1'b0, dx2} + {1'b0, dy2};
    if (take3) begin
      best     <= e3;
      best_idx <= idx3;
    end
    // Emit the previous kept point; it ends the run when no survivor is left
    if (cmd.decide) begin
      result.kept_x        <= cur.x;
      result.kept_y        <= cur.y;
      result.kept_response <= cur.resp;
      result.end_of_run    <= !best_valid;
      result.overflow      <= overflow_seen;
      if (best_valid) begin
        cur <= best;
      end
    end
    // Emit the point kept in the last round when the limit was reached
    if (cmd.finish && best_valid) begin
      result.kept_x        <= cur.x;
      result.kept_y        <= cur.y;
      result.kept_response <= cur.resp;
      result.end_of_run    <= 1'b1;
      result.overflow      <= overflow_seen;
    end
  end

endmodule
`default_nettype wire

FILE: design/greedy_radius_keypoint_suppression.sv
`timescale 1ns / 1ps
`default_nettype none
// Greedy radius suppression of keypoints.
// Requests: a point is taken at a clock edge with start high and busy low.
// Points are stored in arrival order (up to 256); further points are
// dropped and flag overflow on every result of that set. A request with
// is_last high starts processing; busy stays high until the set is done.
// Each round scans all stored points once through the point memory and a
// distance pipeline: points within the radius of the last kept point are
// dropped, and the strongest remaining point (earliest on ties) is kept.
// At most 64 rounds run for a set. Results appear on result for one cycle
// each, marked by result_valid, and cannot be held off; end_of_run marks
// the last result of a set.
// The user must write configuration (cfg_we, cfg_index, cfg_data) while
// idle; the block itself does not enforce this.
// Reset (synchronous, rst) empties the store and restores a radius of 10
// and a feature limit of 64.
module greedy_radius_keypoint_suppression (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire gkps_pkg::point_in_t            req,
  output logic                                busy,
  output logic                                result_valid,
  output gkps_pkg::point_out_t                result,
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_index,
  input  wire logic [gkps_pkg::CFG_BITS-1:0]  cfg_data
);

  gkps_pkg::cmd_t    cmd;
  gkps_pkg::status_t status;

  gkps_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .is_last(req.is_last),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  gkps_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .load        (start && !busy),
    .req         (req),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .status      (status),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule
`default_nettype wire

FILE: bench/tb_greedy_radius_keypoint_suppression.sv
`timescale 1ns / 1ps
module tb_greedy_radius_keypoint_suppression;

  // Predicts kept points of each set and checks them in order
  class keypoint_scoreboard;
    gkps_pkg::point_in_t  set_points[$];
    gkps_pkg::point_out_t kept_queue[$];
    int unsigned radius;
    int unsigned feature_cap;
    bit overflow_pending;
    int errors;

    function new();
      radius = 10;
      feature_cap = 64;
      overflow_pending = 0;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [gkps_pkg::CFG_BITS-1:0] data);
      if (idx == gkps_pkg::REG_RADIUS) radius = data;
      else feature_cap = data[6:0];
    endfunction

    // Store the request; on the last one, run the greedy walk
    function void note_point(gkps_pkg::point_in_t p);
      gkps_pkg::point_in_t order[$];
      bit gone[$];
      int unsigned cap, emitted, k, j;
      longint dx, dy, rsq;
      gkps_pkg::point_out_t o;
      if (set_points.size() < gkps_pkg::MAX_POINTS) set_points.insert(set_points.size(), p);
      else overflow_pending = 1;
      if (!p.is_last) return;
      cap = feature_cap;
      if (cap == 0) cap = 1;
      if (cap > gkps_pkg::RUN_CAP) cap = gkps_pkg::RUN_CAP;
      rsq = longint'(radius) * radius;
      // stable descending sort by response
      foreach (set_points[i]) begin
        k = order.size();
        while (k > 0 && order[k-1].point_response < set_points[i].point_response) k--;
        order.insert(k, set_points[i]);
        gone.insert(gone.size(), 1'b0);
      end
      emitted = 0;
      for (int i = 0; i < order.size(); i++) begin
        if (gone[i]) continue;
        o.kept_x = order[i].point_x;
        o.kept_y = order[i].point_y;
        o.kept_response = order[i].point_response;
        o.end_of_run = 0;
        o.overflow = overflow_pending;
        kept_queue.insert(kept_queue.size(), o);
        emitted++;
        if (emitted >= cap) break;
        for (j = i + 1; j < order.size(); j++) begin
          dx = longint'(order[i].point_x) - longint'(order[j].point_x);
          dy = longint'(order[i].point_y) - longint'(order[j].point_y);
          if (dx * dx + dy * dy < rsq) gone[j] = 1;
        end
      end
      kept_queue[kept_queue.size()-1].end_of_run = 1;
      set_points.delete();
      overflow_pending = 0;
    endfunction

    function void check_result(gkps_pkg::point_out_t r);
      gkps_pkg::point_out_t e;
      if (kept_queue.size() == 0) begin
        $error("unexpected result x=%0d y=%0d", r.kept_x, r.kept_y);
        errors++;
        return;
      end
      e = kept_queue.pop_front();
      if (r.kept_x !== e.kept_x) begin
        $error("kept_x exp %0d got %0d", e.kept_x, r.kept_x); errors++;
      end
      if (r.kept_y !== e.kept_y) begin
        $error("kept_y exp %0d got %0d", e.kept_y, r.kept_y); errors++;
      end
      if (r.kept_response !== e.kept_response) begin
        $error("kept_response exp %0d got %0d", e.kept_response, r.kept_response);
        errors++;
      end
      if (r.end_of_run !== e.end_of_run) begin
        $error("end_of_run exp %0d got %0d", e.end_of_run, r.end_of_run); errors++;
      end
      if (r.overflow !== e.overflow) begin
        $error("overflow exp %0d got %0d", e.overflow, r.overflow); errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, result_valid, cfg_we, cfg_index;
  logic [gkps_pkg::CFG_BITS-1:0] cfg_data;
  gkps_pkg::point_in_t  req;
  gkps_pkg::point_out_t result;
  keypoint_scoreboard sb;
  int idle_cycles;

  greedy_radius_keypoint_suppression dut (
    .clk(clk), .rst(rst), .start(start), .req(req), .busy(busy),
    .result_valid(result_valid), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Check results and watch for a stalled run
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (result_valid) sb.check_result(result);
      if (result_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 60000) begin
        $display("tb_greedy_radius_keypoint_suppression NOT OK");
        $finish;
      end
    end
  end

  function automatic gkps_pkg::point_in_t mk(int x, int y, int r, bit last);
    gkps_pkg::point_in_t p;
    p.point_x = 12'(x);
    p.point_y = 12'(y);
    p.point_response = 16'(r);
    p.is_last = last;
    return p;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Hold the request until taken, then idle for a random gap
  task automatic send_point(gkps_pkg::point_in_t p);
    int unsigned g;
    req = p;
    start = 1'b1;
    do @(posedge clk); while (busy);
    sb.note_point(p);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      start = 1'b0;
      req = mk($urandom_range(0, 4095), $urandom_range(0, 4095),
               $urandom_range(0, 65535), 1'b0);
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (sb.kept_queue.size() != 0 || busy) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [gkps_pkg::CFG_BITS-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Send a random set: clustered or spread, with or without response ties
  task automatic send_set(int n);
    int cx, cy, spread, x, y, r;
    bit ties;
    cx = $urandom_range(0, 4095);
    cy = $urandom_range(0, 4095);
    spread = ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(2, 40);
    ties = $urandom_range(0, 2) == 0;
    for (int i = 0; i < n; i++) begin
      if (spread == 4095) begin
        x = $urandom_range(0, 4095);
        y = $urandom_range(0, 4095);
      end else begin
        x = (cx + $urandom_range(0, spread)) % 4096;
        y = (cy + $urandom_range(0, spread)) % 4096;
      end
      r = ties ? $urandom_range(0, 3) : $urandom_range(0, 65535);
      send_point(mk(x, y, r, i == n - 1));
    end
  endtask

  initial begin
    int sent;
    sb = new();
    rst = 1'b1; start = 1'b0; req = '0;
    cfg_we = 1'b0; cfg_index = gkps_pkg::REG_RADIUS; cfg_data = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed: extremes, ties, clustering, a single point
    send_point(mk(4095, 4095, 65535, 1));
    send_point(mk(0, 0, 0, 1));
    send_point(mk(5, 5, 100, 0));
    send_point(mk(6, 5, 100, 0));
    send_point(mk(100, 100, 100, 0));
    send_point(mk(7, 7, 200, 0));
    send_point(mk(4095, 0, 65535, 0));
    send_point(mk(0, 4095, 65535, 0));
    send_point(mk(15, 5, 50, 1));
    wait_idle();
    write_reg(gkps_pkg::REG_RADIUS, 8'd0);
    write_reg(gkps_pkg::REG_FEAT_LIMIT, 8'd0);
    send_point(mk(1, 1, 9, 0));
    send_point(mk(1, 1, 9, 0));
    send_point(mk(2, 2, 8, 1));
    wait_idle();
    write_reg(gkps_pkg::REG_RADIUS, 8'd255);
    write_reg(gkps_pkg::REG_FEAT_LIMIT, 8'd255);
    send_set(8);
    wait_idle();

    // Store overflow: two points past the depth, the last one marked last
    write_reg(gkps_pkg::REG_RADIUS, 8'd0);
    write_reg(gkps_pkg::REG_FEAT_LIMIT, 8'd64);
    for (int i = 0; i < gkps_pkg::MAX_POINTS + 2; i++)
      send_point(mk($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 65535), i == gkps_pkg::MAX_POINTS + 1));
    wait_idle();

    // Random sets over several register settings
    sent = 0;
    for (int ph = 0; ph < 8 && sent < 180; ph++) begin
      write_reg(gkps_pkg::REG_RADIUS,
                (ph % 3 == 0) ? 8'd255 : 8'($urandom_range(0, 40)));
      write_reg(gkps_pkg::REG_FEAT_LIMIT,
                (ph == 1) ? 8'd1 : (ph == 2) ? 8'd64 : 8'($urandom_range(0, 255)));
      for (int s = 0; s < 4; s++) begin
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
        send_set(n);
        sent += n;
      end
      wait_idle();
    end

    wait_idle();
    repeat (100) @(negedge clk);
    if (sb.errors == 0 && sb.kept_queue.size() == 0)
      $display("tb_greedy_radius_keypoint_suppression OK");
    else
      $display("tb_greedy_radius_keypoint_suppression NOT OK");
    $finish;
  end
endmodule

FILE: sim.f
design/gkps_pkg.sv
design/gkps_ram.sv
design/gkps_ctrl.sv
design/gkps_datapath.sv
design/greedy_radius_keypoint_suppression.sv
bench/tb_greedy_radius_keypoint_suppression.sv
